### rtl/core/fsgs_pkg.sv
// package: shared types, codes and constants of the grip sequencer
`default_nettype none
package fsgs_pkg;

  localparam int SampleBitsDef = 24;
  localparam int FracBitsDef   = 8;

  // operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_MOVE    = 2'd3;

  // phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_BASE  = 2'd1;
  localparam logic [1:0] PH_CLOSE = 2'd2;
  localparam logic [1:0] PH_HOLD  = 2'd3;

  // grip status codes
  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_NOCONTACT = 2'd1;
  localparam logic [1:0] ST_HELD     = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_THRESH  = 3'd0;
  localparam logic [2:0] CFG_CONFIRM = 3'd1;
  localparam logic [2:0] CFG_BASE_N  = 3'd2;
  localparam logic [2:0] CFG_STEP    = 3'd3;
  localparam logic [2:0] CFG_ALPHA   = 3'd4;
  localparam logic [2:0] CFG_SLIP    = 3'd5;
  localparam logic [2:0] CFG_HOLD    = 3'd6;
  localparam logic [2:0] CFG_LIMIT   = 3'd7;

  localparam logic [7:0] MaxAngle = 8'd180;

  typedef struct packed {
    logic [1:0]                    operation;
    logic                          sample_valid;
    logic signed [SampleBitsDef-1:0] load_sample;
    logic [7:0]                    target_angle;
  } in_item_t;

  typedef struct packed {
    logic [7:0] servo_angle;
    logic [1:0] phase;
    logic       contact_seen;
    logic       slip_correction;
    logic [1:0] grip_status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_EMA_A, S_EMA_B, S_SLIP_A, S_SLIP_B, S_FIN, S_OUT
  } seq_state_t;

endpackage
`default_nettype wire

### rtl/core/fsgs_mul.sv
// shared multiplier unit with registered product
`default_nettype none
module fsgs_mul #(
  parameter int AW = 40,
  parameter int BW = 9
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic [AW+BW-1:0]   p_r
);
  // one product per cycle, registered
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

### rtl/core/force_sensing_grip_sequencer.sv
// top level: force-sensing grip sequencer
// Usage: items (operation, sample, target) arrive on the in_ valid/ready
// channel; each accepted item yields exactly one result on the out_ channel.
// The user must write configuration through cfg_we/cfg_index/cfg_data only
// while idle; the block does not enforce this. Most items pass from input
// transfer to out_valid through a decode state, then the output load. A tick
// in the baseline phase that completes the average runs a restoring divide,
// one quotient bit per cycle over SampleBitsDef+5 bits; a hold tick steps
// through S_EMA_A, S_EMA_B, S_SLIP_A and S_SLIP_B on the shared multiplier.
// The block returns to idle after loading the output register and takes no
// new item before then. Reset (rst_n low, synchronous) returns the phase to
// idle, the angle to zero and the state and configuration registers to their
// defaults; item, output data, divider and product registers are not reset.
// When the receiver holds out_ready low the result is held stable, and an
// item taken meanwhile waits in the output load until the result is taken.
`default_nettype none
module force_sensing_grip_sequencer #(
  parameter int FRAC_BITS   = fsgs_pkg::FracBitsDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fsgs_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fsgs_pkg::out_item_t    out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [23:0]       cfg_data
);
  localparam int SW = fsgs_pkg::SampleBitsDef;
  localparam int SUMW = SW + 5;
  localparam int MW = SW + 1;           // magnitude
  localparam int FW = MW + FRAC_BITS;   // fixed point force
  localparam int AW = FW + 9;           // multiplier operand
  localparam int PW = AW + 9;
  localparam int DCW = $clog2(SUMW + 1);

  // configuration registers
  logic [23:0] thresh_r;
  logic [3:0]  confirm_r;
  logic [4:0]  base_n_r, step_r;
  logic [8:0]  alpha_r, slip_r;
  logic [7:0]  hold_r, limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 24'd1000; confirm_r <= 4'd1; base_n_r <= 5'd5; step_r <= 5'd3;
      alpha_r <= 9'd51; slip_r <= 9'd205; hold_r <= 8'd20; limit_r <= 8'd180;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsgs_pkg::CFG_THRESH:  thresh_r  <= cfg_data;
        fsgs_pkg::CFG_CONFIRM: confirm_r <= cfg_data[3:0];
        fsgs_pkg::CFG_BASE_N:  base_n_r  <= cfg_data[4:0];
        fsgs_pkg::CFG_STEP:    step_r    <= cfg_data[4:0];
        fsgs_pkg::CFG_ALPHA:   alpha_r   <= cfg_data[8:0];
        fsgs_pkg::CFG_SLIP:    slip_r    <= cfg_data[8:0];
        fsgs_pkg::CFG_HOLD:    hold_r    <= cfg_data[7:0];
        fsgs_pkg::CFG_LIMIT:   limit_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective register values
  logic [7:0] limit;
  logic [8:0] limit2;
  logic [4:0] base_n;
  logic [3:0] confirm_n;
  logic [4:0] step_n;
  logic [7:0] hold_n;
  logic [8:0] alpha, slip_q;
  always_comb begin
    limit     = (limit_r > fsgs_pkg::MaxAngle) ? fsgs_pkg::MaxAngle : limit_r;
    limit2    = {limit, 1'b0};
    base_n    = (base_n_r == 5'd0) ? 5'd1 : ((base_n_r > 5'd16) ? 5'd16 : base_n_r);
    confirm_n = (confirm_r == 4'd0) ? 4'd1 : confirm_r;
    step_n    = (step_r == 5'd0) ? 5'd1 : step_r;
    hold_n    = (hold_r == 8'd0) ? 8'd1 : hold_r;
    alpha     = (alpha_r > 9'd256) ? 9'd256 : alpha_r;
    slip_q    = (slip_r > 9'd256) ? 9'd256 : slip_r;
  end

  // grip state
  logic [1:0]            phase_r, phase_nxt;
  logic [7:0]            jaw_r, jaw_nxt;
  logic [9:0]            pos_r, pos_nxt;
  logic signed [SUMW-1:0] sum_r, sum_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic signed [SW-1:0]  base_r, base_nxt;
  logic [3:0]            conf_r, conf_nxt;
  logic [7:0]            fca_r, fca_nxt;
  logic                  fcv_r, fcv_nxt;
  logic [FW-1:0]         peak_r, peak_nxt, ema_r, ema_nxt;
  logic [7:0]            hcnt_r, hcnt_nxt;
  logic                  cflag_r, cflag_nxt;

  fsgs_pkg::seq_state_t  st_r, st_nxt;
  fsgs_pkg::in_item_t    item_r, item_nxt;
  logic                  slipo_r, slipo_nxt;
  logic [1:0]            stat_r, stat_nxt;
  logic                  ov_r, ov_nxt;
  fsgs_pkg::out_item_t   od_r, od_nxt;

  // divider registers: magnitude-restoring divide of |sum| by base_n
  logic [SUMW-1:0] dq_r, dq_nxt;
  logic [5:0]      drem_r, drem_nxt;
  logic            dneg_r, dneg_nxt;
  logic [DCW-1:0]  dcnt_r, dcnt_nxt;

  // multiplier operands and product
  logic [AW-1:0] ma;
  logic [8:0]    mb;
  logic [PW-1:0] mp;
  logic [PW-1:0] acc_r, acc_nxt;

  fsgs_mul #(.AW(AW), .BW(9)) u_mul (.clk(clk), .a(ma), .b(mb), .p_r(mp));

  // magnitude of the held sample against the baseline
  logic signed [SW:0] diff;
  logic [MW-1:0]      mag;
  always_comb begin
    diff = $signed({item_r.load_sample[SW-1], item_r.load_sample})
         - $signed({base_r[SW-1], base_r});
    mag  = diff[SW] ? MW'(-diff) : MW'(diff);
  end

  assign in_ready  = (st_r == fsgs_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fsgs_pkg::S_IDLE; ov_r <= 1'b0;
      phase_r <= fsgs_pkg::PH_IDLE; jaw_r <= '0; pos_r <= '0; sum_r <= '0;
      cnt_r <= '0; base_r <= '0; conf_r <= '0; fca_r <= '0; fcv_r <= 1'b0;
      peak_r <= '0; ema_r <= '0; hcnt_r <= '0; cflag_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
      phase_r <= phase_nxt; jaw_r <= jaw_nxt; pos_r <= pos_nxt; sum_r <= sum_nxt;
      cnt_r <= cnt_nxt; base_r <= base_nxt; conf_r <= conf_nxt; fca_r <= fca_nxt;
      fcv_r <= fcv_nxt; peak_r <= peak_nxt; ema_r <= ema_nxt; hcnt_r <= hcnt_nxt;
      cflag_r <= cflag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt; slipo_r <= slipo_nxt; stat_r <= stat_nxt; od_r <= od_nxt;
    dq_r <= dq_nxt; drem_r <= drem_nxt; dneg_r <= dneg_nxt; dcnt_r <= dcnt_nxt;
    acc_r <= acc_nxt;
  end

  // sequencer
  always_comb begin
    logic [9:0]  npos;
    logic        over, hit;
    logic [4:0]  cinc;
    logic [6:0]  trial;
    logic [3:0]  conf_i;
    st_nxt = st_r; ov_nxt = ov_r; od_nxt = od_r; item_nxt = item_r;
    phase_nxt = phase_r; jaw_nxt = jaw_r; pos_nxt = pos_r; sum_nxt = sum_r;
    cnt_nxt = cnt_r; base_nxt = base_r; conf_nxt = conf_r; fca_nxt = fca_r;
    fcv_nxt = fcv_r; peak_nxt = peak_r; ema_nxt = ema_r; hcnt_nxt = hcnt_r;
    cflag_nxt = cflag_r; slipo_nxt = slipo_r; stat_nxt = stat_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dneg_nxt = dneg_r; dcnt_nxt = dcnt_r;
    acc_nxt = acc_r; ma = '0; mb = '0;
    npos = '0; over = 1'b0; hit = 1'b0; cinc = '0; trial = '0; conf_i = '0;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (st_r)
      fsgs_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data; slipo_nxt = 1'b0; stat_nxt = fsgs_pkg::ST_NONE;
          st_nxt = fsgs_pkg::S_FIN;
        end
      end
      // one quotient bit per cycle
      fsgs_pkg::S_DIV: begin
        trial = {drem_r, dq_r[SUMW-1]};
        dq_nxt = {dq_r[SUMW-2:0], 1'b0};
        if (trial >= {2'b0, base_n}) begin
          drem_nxt = 6'(trial - {2'b0, base_n}); dq_nxt[0] = 1'b1;
        end else begin
          drem_nxt = trial[5:0];
        end
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == DCW'(1)) begin
          base_nxt = dneg_r ? SW'(-dq_nxt) : SW'(dq_nxt);
          phase_nxt = fsgs_pkg::PH_CLOSE;
          pos_nxt = {1'b0, jaw_r, 1'b0};
          conf_nxt = '0; fcv_nxt = 1'b0;
          st_nxt = fsgs_pkg::S_OUT;
        end
      end
      // alpha * reading
      fsgs_pkg::S_EMA_A: begin
        ma = AW'({mag, {FRAC_BITS{1'b0}}}); mb = alpha;
        st_nxt = fsgs_pkg::S_EMA_B;
      end
      // (256 - alpha) * ema, then sum
      fsgs_pkg::S_EMA_B: begin
        ma = AW'(ema_r); mb = 9'(9'd256 - alpha);
        acc_nxt = mp;
        st_nxt = fsgs_pkg::S_SLIP_A;
      end
      fsgs_pkg::S_SLIP_A: begin
        if (item_r.sample_valid) ema_nxt = FW'((acc_r + mp) >> 8);
        ma = AW'(peak_r); mb = slip_q;
        st_nxt = fsgs_pkg::S_SLIP_B;
      end
      // slip test and hold count
      fsgs_pkg::S_SLIP_B: begin
        if (PW'({ema_r, 8'd0}) < mp && jaw_r < limit) begin
          jaw_nxt = jaw_r + 8'd1; slipo_nxt = 1'b1;
        end
        if (ema_r > peak_r) peak_nxt = ema_r;
        hcnt_nxt = hcnt_r + 8'd1;
        if (hcnt_nxt >= hold_n) begin
          phase_nxt = fsgs_pkg::PH_IDLE; stat_nxt = fsgs_pkg::ST_HELD;
        end
        st_nxt = fsgs_pkg::S_OUT;
      end
      // decode the item
      fsgs_pkg::S_FIN: begin
        st_nxt = fsgs_pkg::S_OUT;
        unique case (item_r.operation)
          fsgs_pkg::OP_START: begin
            phase_nxt = fsgs_pkg::PH_BASE; sum_nxt = '0; cnt_nxt = '0;
            cflag_nxt = 1'b0;
          end
          fsgs_pkg::OP_RELEASE: begin
            phase_nxt = fsgs_pkg::PH_IDLE; jaw_nxt = '0;
          end
          fsgs_pkg::OP_MOVE: begin
            phase_nxt = fsgs_pkg::PH_IDLE;
            jaw_nxt = (item_r.target_angle > limit) ? limit : item_r.target_angle;
          end
          default: begin
            unique case (phase_r)
              fsgs_pkg::PH_BASE: begin
                cinc = cnt_r;
                if (item_r.sample_valid) begin
                  sum_nxt = sum_r + SUMW'(item_r.load_sample);
                  cinc = cnt_r + 5'd1;
                end
                cnt_nxt = cinc;
                if (cinc >= base_n) begin
                  dneg_nxt = sum_nxt[SUMW-1];
                  dq_nxt = sum_nxt[SUMW-1] ? SUMW'(-sum_nxt) : SUMW'(sum_nxt);
                  drem_nxt = '0; dcnt_nxt = DCW'(SUMW);
                  st_nxt = fsgs_pkg::S_DIV;
                end
              end
              fsgs_pkg::PH_CLOSE: begin
                if (pos_r > {1'b0, limit2}) begin
                  phase_nxt = fsgs_pkg::PH_IDLE; stat_nxt = fsgs_pkg::ST_NOCONTACT;
                end else begin
                  jaw_nxt = pos_r[8:1];
                  if (item_r.sample_valid) begin
                    over = mag > MW'(thresh_r);
                    if (over) begin
                      if (!fcv_r) begin
                        fca_nxt = pos_r[8:1]; fcv_nxt = 1'b1;
                      end
                      conf_i = (conf_r < 4'd15) ? conf_r + 4'd1 : conf_r;
                      conf_nxt = conf_i;
                      if (conf_i >= confirm_n) begin
                        hit = 1'b1; peak_nxt = FW'({mag, {FRAC_BITS{1'b0}}});
                      end
                    end else begin
                      fcv_nxt = 1'b0; conf_nxt = '0;
                    end
                  end
                  npos = pos_r + 10'(step_n);
                  pos_nxt = npos;
                  if (hit) begin
                    if (fcv_nxt) jaw_nxt = fca_nxt;
                    if (jaw_nxt > limit) jaw_nxt = limit;
                    ema_nxt = peak_nxt; hcnt_nxt = '0; cflag_nxt = 1'b1;
                    phase_nxt = fsgs_pkg::PH_HOLD;
                  end else if (npos > {1'b0, limit2}) begin
                    phase_nxt = fsgs_pkg::PH_IDLE; stat_nxt = fsgs_pkg::ST_NOCONTACT;
                  end
                end
              end
              fsgs_pkg::PH_HOLD: st_nxt = fsgs_pkg::S_EMA_A;
              default: ;
            endcase
          end
        endcase
      end
      // load the output register once it is free
      fsgs_pkg::S_OUT: begin
        if (!ov_r || out_ready) begin
          od_nxt.servo_angle = jaw_r; od_nxt.phase = phase_r;
          od_nxt.contact_seen = cflag_r; od_nxt.slip_correction = slipo_r;
          od_nxt.grip_status = stat_r;
          ov_nxt = 1'b1; st_nxt = fsgs_pkg::S_IDLE;
        end
      end
      default: st_nxt = fsgs_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
